// ----- hw/rtl/box_filter_image_downscaler_top_defines.svh -----
// Assertion macros used by the box filter downscaler checker.
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_TOP_DEFINES_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BFD_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define BFD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is applied.
`define BFD_CHECK_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bfd_pkg.sv -----
// Shared types and constants of the box filter image downscaler.
`default_nettype none

package bfd_pkg;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int FACTOR_W   = 5;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int RUN_W      = 12;
    localparam int SUM_W      = 16;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Limits and defaults.
    localparam int MAX_FACTOR    = 16;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int PIX_MAX       = 255;
    localparam int FACTOR_RST    = 1;
    localparam int WIDTH_RST     = 4096;
    localparam int HEIGHT_RST    = 4096;

    // Divider operand widths: numerator covers 2*sum + f*f, divisor covers 2*f*f.
    localparam int DIV_NW = 18;
    localparam int DIV_DW = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Operand selection of the shared divider.
    typedef enum logic [1:0] {
        DIV_WIDTH,
        DIV_HEIGHT,
        DIV_AVG
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_pix;
        logic     commit;
        logic     rd_en;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_ow;
        logic     load_oh;
        logic     load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic grp_done;
        logic final_row;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/box_filter_image_downscaler_top.sv -----
// Top level of the box filter image downscaler.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_pixel_in
//  m_        out        m_valid/m_ready    m_pixel_out, m_last_of_frame
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// A pixel that completes no square is accepted, then accumulated; one that completes a square on
// an upper row of its block also passes the sum state (line store read, then sum and write back).
// A pixel that completes a square on the last row of its block then waits for the shared 18-step
// restoring divider, which forms the rounded average, and for the output register.
// Reset and each configuration write schedule two divisions (width and height by the factor),
// during which no pixel is taken; a write that lands while they run schedules them again.
// The result sits in an output register, so a stalled consumer holds up the block
// only when the next result is ready. The line store has no reset pass.
`default_nettype none

module box_filter_image_downscaler_top #(
    parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [bfd_pkg::PIX_W-1:0]          s_pixel_in,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [bfd_pkg::PIX_W-1:0]          m_pixel_out,
    output logic                                    m_last_of_frame,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    bfd_pkg::dp_cmd_t  cmd;
    bfd_pkg::dp_stat_t stat;

    // Sequencing of each transaction.
    bfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_wr_en (cfg_wr_en),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Sums, line store and averaging.
    bfd_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_pixel_in      (s_pixel_in),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_pixel_out     (m_pixel_out),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bfd_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module bfd_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bfd_pkg::DIV_NW-1:0]    num,
    input  wire logic [bfd_pkg::DIV_DW-1:0]    den,
    output logic      [bfd_pkg::DIV_NW-1:0]    quot,
    output logic      [bfd_pkg::DIV_DW-1:0]    rem,
    output logic                               done
);

    localparam int NW    = bfd_pkg::DIV_NW;
    localparam int DW    = bfd_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NW-1:0]     acc_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     den_reg;

    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              fits;

    // One restoring step: shift in the next numerator bit and try the divisor.
    always_comb begin
        trial = {rem_reg, acc_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Sequencing of the iterations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            acc_reg <= {acc_reg[NW-2:0], fits};
        end
    end

    assign quot = acc_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bfd_ctrl.sv -----
// Controller state machine of the box filter image downscaler.
`default_nettype none

module bfd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire logic              cfg_wr_en,
    input  wire bfd_pkg::dp_stat_t stat,
    output bfd_pkg::dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT_W,
        S_WAIT_H,
        S_ACC,
        S_SUM,
        S_DIV,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   dirty_reg;
    logic   dirty_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        dirty_next   = dirty_reg | cfg_wr_en;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        cmd.div_sel  = bfd_pkg::DIV_WIDTH;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (dirty_reg) begin
                    // Derived frame bounds are stale: recompute them first.
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bfd_pkg::DIV_WIDTH;
                    dirty_next    = cfg_wr_en;
                    state_next    = S_WAIT_W;
                end else if (!cfg_wr_en) begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.load_pix = 1'b1;
                        state_next   = S_ACC;
                    end
                end
            end
            S_WAIT_W: begin
                if (stat.div_done) begin
                    cmd.load_ow   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bfd_pkg::DIV_HEIGHT;
                    state_next    = S_WAIT_H;
                end
            end
            S_WAIT_H: begin
                if (stat.div_done) begin
                    cmd.load_oh = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_ACC: begin
                if (stat.grp_done) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SUM;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SUM: begin
                cmd.commit = 1'b1;
                if (stat.final_row) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bfd_pkg::DIV_AVG;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, pending-configuration flag and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            dirty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bfd_dp.sv -----
// Datapath: configuration, counters, line store, divider and output register.
`default_nettype none

module bfd_dp #(
    parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire bfd_pkg::dp_cmd_t                   cmd,
    output bfd_pkg::dp_stat_t                       stat,
    input  wire logic [bfd_pkg::PIX_W-1:0]          s_pixel_in,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic      [bfd_pkg::PIX_W-1:0]          m_pixel_out,
    output logic                                    m_last_of_frame
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int XW  = (CW + 1 > bfd_pkg::WIDTH_W) ? CW + 1 : bfd_pkg::WIDTH_W;
    localparam int FW  = bfd_pkg::FACTOR_W;
    localparam int HW  = bfd_pkg::HEIGHT_W;
    localparam int PW  = bfd_pkg::PHASE_W;
    localparam int RW  = bfd_pkg::RUN_W;
    localparam int SW  = bfd_pkg::SUM_W;
    localparam int NW  = bfd_pkg::DIV_NW;
    localparam int DW  = bfd_pkg::DIV_DW;

    // Configuration registers.
    logic [FW-1:0]               factor_reg;
    logic [bfd_pkg::WIDTH_W-1:0] width_reg;
    logic [HW-1:0]               height_reg;

    // Scan state.
    logic [CW-1:0] col_cnt_reg;
    logic [HW-1:0] row_cnt_reg;
    logic [PW-1:0] x_ph_reg;
    logic [PW-1:0] y_ph_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] run_sum_reg;

    // Payload registers.
    logic [bfd_pkg::PIX_W-1:0] pix_reg;
    logic [SW-1:0]             rdata_reg;
    logic [XW-1:0]             ow_reg;
    logic [XW-1:0]             owf_reg;
    logic [HW-1:0]             ohf_reg;
    logic                      last_reg;
    logic [bfd_pkg::PIX_W-1:0] pix_out_reg;
    logic                      last_out_reg;

    // Line store of partial column sums.
    logic [SW-1:0] col_sums [MAX_WIDTH];

    // Combinational values.
    logic [FW-1:0] f_eff;
    logic [XW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [FW-1:0] x_inc;
    logic [FW-1:0] y_inc;
    logic          grp_hit;
    logic          in_region;
    logic          grp_done;
    logic          final_row;
    logic [RW-1:0] run_add;
    logic [SW-1:0] prev_sum;
    logic [SW-1:0] blk_sum;
    logic [DW-1:0] ff;
    logic [NW-1:0] avg_num;
    logic [DW-1:0] avg_den;
    logic [XW-1:0] col_inc;
    logic          row_end;
    logic [HW:0]   row_inc;
    logic          frame_end;
    logic [XW-1:0] oc_inc;
    logic          last_hit;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [NW-1:0] div_quot;
    logic [DW-1:0] div_rem;
    logic          div_done;

    // Effective register values after the out-of-range rules.
    always_comb begin
        if (factor_reg == '0) begin
            f_eff = FW'(1);
        end else if (factor_reg > FW'(bfd_pkg::MAX_FACTOR)) begin
            f_eff = FW'(bfd_pkg::MAX_FACTOR);
        end else begin
            f_eff = factor_reg;
        end
        if (width_reg == '0) begin
            w_eff = XW'(1);
        end else if (XW'(width_reg) > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(width_reg);
        end
        h_eff = (height_reg == '0) ? HW'(1) : height_reg;
    end

    // Square bookkeeping for the current pixel.
    always_comb begin
        x_inc     = {1'b0, x_ph_reg} + FW'(1);
        y_inc     = {1'b0, y_ph_reg} + FW'(1);
        grp_hit   = (x_inc >= f_eff);
        final_row = (y_inc >= f_eff);
        in_region = (XW'(col_cnt_reg) < owf_reg) && (row_cnt_reg < ohf_reg);
        grp_done  = in_region && grp_hit;
        run_add   = run_sum_reg + RW'(pix_reg);
        prev_sum  = (y_ph_reg != '0) ? rdata_reg : '0;
        blk_sum   = prev_sum + SW'(run_add);
        ff        = DW'(f_eff) * DW'(f_eff);
        avg_num   = {1'b0, blk_sum, 1'b0} + NW'(ff);
        avg_den   = {ff[DW-2:0], 1'b0};
        col_inc   = XW'(col_cnt_reg) + XW'(1);
        row_end   = (col_inc >= w_eff);
        row_inc   = {1'b0, row_cnt_reg} + (HW + 1)'(1);
        frame_end = (row_inc >= {1'b0, h_eff});
        oc_inc    = XW'(out_col_reg) + XW'(1);
        last_hit  = (row_inc >= {1'b0, ohf_reg}) && (oc_inc >= ow_reg);
    end

    // Divider operand selection.
    always_comb begin
        unique case (cmd.div_sel)
            bfd_pkg::DIV_WIDTH: begin
                div_num = NW'(w_eff);
                div_den = DW'(f_eff);
            end
            bfd_pkg::DIV_HEIGHT: begin
                div_num = NW'(h_eff);
                div_den = DW'(f_eff);
            end
            bfd_pkg::DIV_AVG: begin
                div_num = avg_num;
                div_den = avg_den;
            end
            default: begin
                div_num = avg_num;
                div_den = avg_den;
            end
        endcase
    end

    bfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .rem     (div_rem),
        .done    (div_done)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FW'(bfd_pkg::FACTOR_RST);
            width_reg  <= bfd_pkg::WIDTH_W'(bfd_pkg::WIDTH_RST);
            height_reg <= HW'(bfd_pkg::HEIGHT_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bfd_pkg::CFG_FACTOR: factor_reg <= cfg_wdata[FW-1:0];
                bfd_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[bfd_pkg::WIDTH_W-1:0];
                bfd_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[HW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Scan counters and running row sum, updated once per pixel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            x_ph_reg    <= '0;
            y_ph_reg    <= '0;
            out_col_reg <= '0;
            run_sum_reg <= '0;
        end else if (cmd.commit) begin
            if (row_end) begin
                col_cnt_reg <= '0;
                x_ph_reg    <= '0;
                run_sum_reg <= '0;
                out_col_reg <= '0;
                if (frame_end) begin
                    row_cnt_reg <= '0;
                    y_ph_reg    <= '0;
                end else begin
                    row_cnt_reg <= row_inc[HW-1:0];
                    y_ph_reg    <= final_row ? '0 : y_inc[PW-1:0];
                end
            end else begin
                col_cnt_reg <= col_inc[CW-1:0];
                if (in_region) begin
                    if (grp_hit) begin
                        x_ph_reg    <= '0;
                        run_sum_reg <= '0;
                        out_col_reg <= oc_inc[CW-1:0];
                    end else begin
                        x_ph_reg    <= x_inc[PW-1:0];
                        run_sum_reg <= run_add;
                    end
                end
            end
        end
    end

    // Line store: a block row's partial sum is written on all but its last row.
    always_ff @(posedge aclk) begin
        if (cmd.commit && grp_done && !final_row) begin
            col_sums[out_col_reg] <= blk_sum;
        end
        if (cmd.rd_en) begin
            rdata_reg <= col_sums[out_col_reg];
        end
    end

    // Pixel capture, derived frame bounds and the result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_pix) begin
            pix_reg <= s_pixel_in;
        end
        if (cmd.load_ow) begin
            ow_reg  <= div_quot[XW-1:0];
            owf_reg <= w_eff - XW'(div_rem);
        end
        if (cmd.load_oh) begin
            ohf_reg <= h_eff - HW'(div_rem);
        end
        if (cmd.div_start && (cmd.div_sel == bfd_pkg::DIV_AVG)) begin
            last_reg <= last_hit;
        end
        if (cmd.load_out) begin
            pix_out_reg  <= (div_quot > NW'(bfd_pkg::PIX_MAX)) ?
                            bfd_pkg::PIX_W'(bfd_pkg::PIX_MAX) :
                            div_quot[bfd_pkg::PIX_W-1:0];
            last_out_reg <= last_reg;
        end
    end

    assign stat.grp_done    = grp_done;
    assign stat.final_row   = final_row;
    assign stat.div_done    = div_done;
    assign m_pixel_out      = pix_out_reg;
    assign m_last_of_frame  = last_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bfd_checker.sv -----
// Port-level checker of the box filter image downscaler and its bind.
`default_nettype none
`include "box_filter_image_downscaler_top_defines.svh"

module bfd_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [bfd_pkg::PIX_W-1:0] m_pixel_out,
    input wire logic                      m_last_of_frame,
    input wire logic                      cfg_wr_en
);

    // A stalled result holds its value.
    `BFD_CHECK_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_pixel_out) && $stable(m_last_of_frame), "result changed while stalled")

    // A configuration write is never taken in the same cycle as a pixel.
    `BFD_CHECK(a_cfg_blocks_input, cfg_wr_en, !s_ready, "pixel accepted during a configuration write")

    // Pixels are processed one at a time.
    `BFD_CHECK_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "input ready right after a transaction")

    // Reset empties the output and starts the bound computation.
    `BFD_CHECK_RESET(a_reset_quiet, !m_valid && !s_ready, "block not quiet after reset")

endmodule

bind box_filter_image_downscaler_top bfd_checker u_bfd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pixel_out     (m_pixel_out),
    .m_last_of_frame (m_last_of_frame),
    .cfg_wr_en       (cfg_wr_en)
);

`default_nettype wire
